// ===== hw/rtl/hnps_pkg.sv =====
// Shared constants and types for the highest-note priority stack.
`timescale 1ns / 1ps
`default_nettype none

package hnps_pkg;

    // Number of distinct notes the stack can hold.
    localparam int DEPTH = 8;

    // Index width into the note store, and width of a count 0..DEPTH.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam int NOTE_W   = 7;
    localparam int OP_W     = 2;
    localparam int COUNT_W  = 4;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 2'd0,
        OP_RELEASE = 2'd1,
        OP_CLEAR   = 2'd2
    } t_opcode;

endpackage

`default_nettype wire

// ===== hw/rtl/hnps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module hnps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/highest_note_priority_stack.sv =====
// A clear or an unused opcode goes straight to the result; a push or release first scans
// the held notes from the top, then may shift entries, and a push last writes its note.
// One item at a time: the next is accepted only once the result loads into the output
// register; a full output register holds the block until taken.
// Each scan or shift step reads the note RAM, whose read port is registered, then uses the data.
// Reset: i_rst_n (synchronous, active low) empties the stack and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module highest_note_priority_stack
    import hnps_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Slave side, tdata: opcode [1:0], note [8:2], zero [15:9]
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    input  wire logic [S_DATA_W-1:0] i_s_tdata,
    // Master side, tdata: top_valid [0], top_note [7:1], held_count [11:8], zero [15:12]
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    output logic      [M_DATA_W-1:0] o_m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_INSERT,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [OP_W-1:0]     r_op, n_op;
    logic [NOTE_W-1:0]   r_note, n_note;
    logic [CW-1:0]       r_total, n_total;
    logic [CW-1:0]       r_pos, n_pos;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_dir_up, n_dir_up;
    logic [NOTE_W-1:0]   r_top, n_top;
    logic                r_out_valid, n_out_valid;
    logic                r_out_top_valid, n_out_top_valid;
    logic [NOTE_W-1:0]   r_out_note, n_out_note;
    logic [CW-1:0]       r_out_count, n_out_count;

    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [NOTE_W-1:0]   w_wdata;
    logic [AW-1:0]       w_raddr;
    logic [NOTE_W-1:0]   w_rdata;

    logic [CW-1:0]       w_pos_inc;
    logic [CW-1:0]       w_idx_inc;
    logic [CW-1:0]       w_idx_dec;
    logic [CW-1:0]       w_total_dec;
    logic [CW-1:0]       w_total_grow;
    logic                w_full;
    logic [31:0]         w_count_ext;

    hnps_ram #(
        .WIDTH (NOTE_W),
        .DEPTH (DEPTH)
    ) u_note_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_pos_inc    = CW'(r_pos + 1'b1);
    assign w_idx_inc    = CW'(r_idx + 1'b1);
    assign w_idx_dec    = CW'(r_idx - 1'b1);
    assign w_total_dec  = CW'(r_total - 1'b1);
    assign w_full       = (r_total == CW'(DEPTH));
    assign w_total_grow = w_full ? r_total : CW'(r_total + 1'b1);

    always_comb begin
        n_state         = r_state;
        n_op            = r_op;
        n_note          = r_note;
        n_total         = r_total;
        n_pos           = r_pos;
        n_idx           = r_idx;
        n_dir_up        = r_dir_up;
        n_out_valid     = r_out_valid;
        n_out_top_valid = r_out_top_valid;
        n_out_note      = r_out_note;
        n_out_count     = r_out_count;

        w_we    = 1'b0;
        w_waddr = r_idx[AW-1:0];
        w_wdata = w_rdata;
        w_raddr = r_pos[AW-1:0];

        // Drop the result once the downstream side takes it.
        if (i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_op   = i_s_tdata[OP_W-1:0];
                    n_note = i_s_tdata[OP_W +: NOTE_W];
                    n_pos  = '0;
                    if (i_s_tdata[OP_W-1:0] == OP_PUSH) begin
                        n_state = (r_total == '0) ? S_INSERT : S_SCAN_RD;
                    end else if (i_s_tdata[OP_W-1:0] == OP_RELEASE) begin
                        n_state = (r_total == '0) ? S_DONE : S_SCAN_RD;
                    end else if (i_s_tdata[OP_W-1:0] == OP_CLEAR) begin
                        n_total = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN_RD: begin
                w_raddr = r_pos[AW-1:0];
                n_state = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                if (r_op == OP_PUSH) begin
                    if (w_rdata == r_note) begin
                        n_state = S_DONE;
                    end else if (w_rdata < r_note) begin
                        n_state = S_INSERT;
                    end else begin
                        n_pos   = w_pos_inc;
                        n_state = (w_pos_inc == r_total) ? S_INSERT : S_SCAN_RD;
                    end
                end else begin
                    if (w_rdata == r_note) begin
                        // Close the gap: entries below move up one place.
                        n_total  = w_total_dec;
                        n_idx    = r_pos;
                        n_dir_up = 1'b1;
                        n_state  = (r_pos < w_total_dec) ? S_SHIFT_RD : S_DONE;
                    end else begin
                        n_pos   = w_pos_inc;
                        n_state = (w_pos_inc == r_total) ? S_DONE : S_SCAN_RD;
                    end
                end
            end
            S_INSERT: begin
                if (r_pos >= CW'(DEPTH)) begin
                    // Full and lower than every held note: ignore.
                    n_state = S_DONE;
                end else begin
                    n_total  = w_total_grow;
                    n_idx    = CW'(w_total_grow - 1'b1);
                    n_dir_up = 1'b0;
                    n_state  = (CW'(w_total_grow - 1'b1) > r_pos) ? S_SHIFT_RD : S_PUT;
                end
            end
            S_SHIFT_RD: begin
                w_raddr = r_dir_up ? w_idx_inc[AW-1:0] : w_idx_dec[AW-1:0];
                n_state = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                w_we    = 1'b1;
                w_waddr = r_idx[AW-1:0];
                w_wdata = w_rdata;
                if (r_dir_up) begin
                    n_idx   = w_idx_inc;
                    n_state = (w_idx_inc < r_total) ? S_SHIFT_RD : S_DONE;
                end else begin
                    n_idx   = w_idx_dec;
                    n_state = (w_idx_dec > r_pos) ? S_SHIFT_RD : S_PUT;
                end
            end
            S_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_pos[AW-1:0];
                w_wdata = r_note;
                n_state = S_DONE;
            end
            S_DONE: begin
                // Hold until the output register is free.
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid     = 1'b1;
                    n_out_top_valid = (r_total != '0);
                    n_out_note      = (r_total != '0) ? r_top : '0;
                    n_out_count     = r_total;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Mirror of entry zero, so the top note needs no extra RAM read.
    always_comb begin
        n_top = r_top;
        if (w_we && (w_waddr == '0)) begin
            n_top = w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
        r_op            <= n_op;
        r_note          <= n_note;
        r_pos           <= n_pos;
        r_idx           <= n_idx;
        r_dir_up        <= n_dir_up;
        r_top           <= n_top;
        r_out_top_valid <= n_out_top_valid;
        r_out_note      <= n_out_note;
        r_out_count     <= n_out_count;
    end

    assign w_count_ext = 32'(r_out_count);

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {
        (M_DATA_W - COUNT_W - NOTE_W - 1)'(0),
        w_count_ext[COUNT_W-1:0],
        r_out_note,
        r_out_top_valid
    };

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(DEPTH))
        else $error("held count exceeds stack depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("accepted a second item while busy");

    a_result_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_top_valid == (r_out_count != '0)))
        else $error("top valid disagrees with held count");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (CW'(w_waddr) < r_total))
        else $error("note write outside the held range");

    a_empty_top_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_top_valid) |-> (r_out_note == '0))
        else $error("empty result carries a nonzero note");

endmodule

`default_nettype wire
